/* sv/spectrum_bin_colorizer_core_macros.svh */
// Assertion helpers for the spectrum bin colouriser.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef SPECTRUM_BIN_COLORIZER_CORE_MACROS_SVH
`define SPECTRUM_BIN_COLORIZER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define SBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SBC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* sv/sbc_pkg.sv */
package sbc_pkg;

  localparam int unsigned FFT_LENGTH_DEFAULT = 2048;

  // Configuration port: one 32-bit register at byte address 0.
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_DB_RANGE = 1'b0;
  localparam logic [7:0] DB_RANGE_RESET = 8'd85;

  // 5*log10(2) in Q16, rounded.
  localparam logic [16:0] DB_K = 17'd98642;

  localparam int unsigned FRAC_W = 16;
  localparam int unsigned L2_MAG_W = 23;
  localparam logic [L2_MAG_W-1:0] L2_ZERO_MAG = 23'(30 * 65536);

  localparam int unsigned DIV_W = 24;
  localparam int unsigned DIV_STEP = 4;
  localparam int unsigned DIV_STAGES = DIV_W / DIV_STEP;

  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [16:0] HALF_SCALE = 17'h08000;
  localparam logic [23:0] RED_CLAMP = 24'(255 * 65536);
  localparam logic [7:0] FULL_LEVEL = 8'd255;

  typedef struct packed {
    logic        valid;
    logic [63:0] pw;
  } pw_beat_t;

  typedef struct packed {
    logic                valid;
    logic                neg;
    logic [L2_MAG_W-1:0] mag;
  } l2_beat_t;

  typedef struct packed {
    logic             valid;
    logic             neg;
    logic [DIV_W-1:0] quo;
  } quo_beat_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
  } pix_beat_t;

  // Q16 base-2 logarithm, evaluated at elaboration for the length correction.
  function automatic logic [21:0] log2_q16(input logic [63:0] x);
    logic [5:0]  e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) begin
        e = 6'(i);
      end
    end
    if (e >= 6'd30) begin
      m = x >> (e - 6'd30);
    end else begin
      m = x << (6'd30 - e);
    end
    frac = 16'd0;
    for (int j = 0; j < 16; j++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {e, frac};
  endfunction

endpackage

/* sv/sbc_power.sv */
module sbc_power (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               take,
  input  logic signed [31:0] bin_real,
  input  logic signed [31:0] bin_imag,
  output sbc_pkg::pw_beat_t  pw_out
);

  logic [31:0] re_abs;
  logic [31:0] im_abs;
  logic [63:0] re_sq;
  logic [63:0] im_sq;
  logic        a_valid;
  logic [62:0] sq_re;
  logic [62:0] sq_im;
  logic        b_valid;
  logic [63:0] pw;

  assign re_abs = bin_real[31] ? (~bin_real + 32'd1) : bin_real;
  assign im_abs = bin_imag[31] ? (~bin_imag + 32'd1) : bin_imag;
  assign re_sq  = {32'd0, re_abs} * {32'd0, re_abs};
  assign im_sq  = {32'd0, im_abs} * {32'd0, im_abs};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= take;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_re <= re_sq[62:0];
      sq_im <= im_sq[62:0];
      pw    <= {1'b0, sq_re} + {1'b0, sq_im};
    end
  end

  assign pw_out.valid = b_valid;
  assign pw_out.pw    = pw;

endmodule

/* sv/sbc_log2.sv */
module sbc_log2 #(
  parameter int unsigned FFT_LENGTH = sbc_pkg::FFT_LENGTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  sbc_pkg::pw_beat_t pw_in,
  output sbc_pkg::l2_beat_t l2_out
);

  localparam int unsigned R = sbc_pkg::FRAC_W;
  // 40 fraction bits of the squared Q11.20 input plus log2 of the length squared.
  localparam logic [22:0] L2_OFFSET = 23'(40 * 65536)
    + 23'(sbc_pkg::log2_q16(64'(FFT_LENGTH) * 64'(FFT_LENGTH)));

  // Coarse leading-one search: highest non-zero byte.
  logic [2:0]  byte_idx;
  logic        any_nz;
  logic        c_valid;
  logic        c_zero;
  logic [2:0]  c_byte;
  logic [63:0] c_y;

  always_comb begin
    byte_idx = 3'd0;
    any_nz   = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (|pw_in.pw[8*i +: 8]) begin
        byte_idx = 3'(i);
        any_nz   = 1'b1;
      end
    end
  end

  // Fine search within the top byte, then normalise to Q1.30.
  logic [2:0]  bit_idx;
  logic [63:0] c_z;
  logic        d_valid;
  logic        d_zero;
  logic [5:0]  d_e;
  logic [30:0] d_m;

  always_comb begin
    bit_idx = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (c_y[56 + i]) begin
        bit_idx = 3'(i);
      end
    end
  end

  assign c_z = c_y << (3'd7 - bit_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= pw_in.valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_zero <= !any_nz;
      c_byte <= byte_idx;
      c_y    <= pw_in.pw << {~byte_idx, 3'b000};
      d_zero <= c_zero;
      d_e    <= {c_byte, bit_idx};
      d_m    <= c_z[63:33];
    end
  end

  // One squaring round per stage yields one fraction bit.
  logic        rd_valid [R];
  logic        rd_zero  [R];
  logic [5:0]  rd_e     [R];
  logic [30:0] rd_m     [R];
  logic [R-1:0] rd_frac [R];

  genvar j;
  for (j = 0; j < R; j++) begin : g_round
    logic         v_src;
    logic         z_src;
    logic [5:0]   e_src;
    logic [30:0]  m_src;
    logic [R-1:0] f_src;
    logic [61:0]  sq;
    logic [31:0]  v;

    if (j == 0) begin : g_first
      assign v_src = d_valid;
      assign z_src = d_zero;
      assign e_src = d_e;
      assign m_src = d_m;
      assign f_src = '0;
    end else begin : g_next
      assign v_src = rd_valid[j-1];
      assign z_src = rd_zero[j-1];
      assign e_src = rd_e[j-1];
      assign m_src = rd_m[j-1];
      assign f_src = rd_frac[j-1];
    end

    assign sq = {31'd0, m_src} * {31'd0, m_src};
    assign v  = sq[61:30];

    always_ff @(posedge clk) begin
      if (rst) begin
        rd_valid[j] <= 1'b0;
      end else if (adv) begin
        rd_valid[j] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_zero[j] <= z_src;
        rd_e[j]    <= e_src;
        rd_m[j]    <= v[31] ? v[31:1] : v[30:0];
        rd_frac[j] <= {f_src[R-2:0], v[31]};
      end
    end
  end

  // Remove the fixed-point and length offsets; keep sign and magnitude.
  logic signed [24:0] diff;
  logic signed [24:0] ndiff;
  logic               e_valid;
  logic               e_neg;
  logic [22:0]        e_mag;

  assign diff  = $signed({3'b000, rd_e[R-1], rd_frac[R-1]}) - $signed({2'b00, L2_OFFSET});
  assign ndiff = -diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= rd_valid[R-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (rd_zero[R-1]) begin
        e_neg <= 1'b1;
        e_mag <= sbc_pkg::L2_ZERO_MAG;
      end else begin
        e_neg <= diff[24];
        e_mag <= diff[24] ? ndiff[22:0] : diff[22:0];
      end
    end
  end

  assign l2_out.valid = e_valid;
  assign l2_out.neg   = e_neg;
  assign l2_out.mag   = e_mag;

endmodule

/* sv/sbc_div.sv */
module sbc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [7:0]         db_range,
  input  sbc_pkg::l2_beat_t  l2_in,
  output sbc_pkg::quo_beat_t quo_out
);

  localparam int unsigned W = sbc_pkg::DIV_W;
  localparam int unsigned STEP = sbc_pkg::DIV_STEP;
  localparam int unsigned N = sbc_pkg::DIV_STAGES;

  logic [7:0]  divisor;
  logic [39:0] prod;
  logic        f_valid;
  logic        f_neg;
  logic [W-1:0] f_t;

  assign divisor = (db_range == 8'd0) ? 8'd1 : db_range;
  assign prod    = {17'd0, l2_in.mag} * {23'd0, sbc_pkg::DB_K};

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= l2_in.valid;
    end
  end

  // Dropping 16 bits first does not change the truncated quotient.
  always_ff @(posedge clk) begin
    if (adv) begin
      f_neg <= l2_in.neg;
      f_t   <= prod[39:16];
    end
  end

  logic         dv_valid [N];
  logic         dv_neg   [N];
  logic [7:0]   dv_rem   [N];
  logic [W-1:0] dv_t     [N];
  logic [W-1:0] dv_q     [N];

  genvar i;
  for (i = 0; i < N; i++) begin : g_stage
    logic         v_src;
    logic         n_src;
    logic [7:0]   r_src;
    logic [W-1:0] t_src;
    logic [W-1:0] q_src;
    logic [7:0]   r;
    logic [8:0]   r9;
    logic [STEP-1:0] qb;

    if (i == 0) begin : g_first
      assign v_src = f_valid;
      assign n_src = f_neg;
      assign r_src = 8'd0;
      assign t_src = f_t;
      assign q_src = '0;
    end else begin : g_next
      assign v_src = dv_valid[i-1];
      assign n_src = dv_neg[i-1];
      assign r_src = dv_rem[i-1];
      assign t_src = dv_t[i-1];
      assign q_src = dv_q[i-1];
    end

    always_comb begin
      r  = r_src;
      r9 = 9'd0;
      qb = '0;
      for (int b = 0; b < STEP; b++) begin
        r9 = {r, t_src[W-1-b]};
        if (r9 >= {1'b0, divisor}) begin
          r9 = r9 - {1'b0, divisor};
          qb[STEP-1-b] = 1'b1;
        end
        r = r9[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i] <= 1'b0;
      end else if (adv) begin
        dv_valid[i] <= v_src;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_neg[i] <= n_src;
        dv_rem[i] <= r;
        dv_t[i]   <= t_src << STEP;
        dv_q[i]   <= {q_src[W-STEP-1:0], qb};
      end
    end
  end

  assign quo_out.valid = dv_valid[N-1];
  assign quo_out.neg   = dv_neg[N-1];
  assign quo_out.quo   = dv_q[N-1];

endmodule

/* sv/sbc_color.sv */
module sbc_color (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  sbc_pkg::quo_beat_t quo_in,
  output sbc_pkg::pix_beat_t pix_out
);

  logic [16:0] s;
  logic [25:0] r26;
  logic [23:0] rc;
  logic [24:0] rsum;
  logic [15:0] gs;
  logic [23:0] g;
  logic [24:0] gsum;
  logic        p_valid;
  logic [7:0]  p_red;
  logic [7:0]  p_green;

  // Level in Q16, clamped to [0, 1].
  always_comb begin
    if (!quo_in.neg) begin
      s = sbc_pkg::Q16_ONE;
    end else if (quo_in.quo >= {7'd0, sbc_pkg::Q16_ONE}) begin
      s = 17'd0;
    end else begin
      s = sbc_pkg::Q16_ONE - {1'b0, quo_in.quo[15:0]};
    end
  end

  assign r26  = ({9'd0, s} << 9) - ({9'd0, s} << 1);
  assign rc   = (r26 > {2'b00, sbc_pkg::RED_CLAMP}) ? sbc_pkg::RED_CLAMP : r26[23:0];
  assign rsum = {1'b0, rc} + 25'h00FFFF;

  assign gs   = (s >= sbc_pkg::HALF_SCALE) ? 16'(s - sbc_pkg::HALF_SCALE) : 16'd0;
  assign g    = ({8'd0, gs} << 9) - ({8'd0, gs} << 1);
  assign gsum = {1'b0, g} + 25'h00FFFF;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= quo_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_red   <= sbc_pkg::FULL_LEVEL - rsum[23:16];
      p_green <= sbc_pkg::FULL_LEVEL - gsum[23:16];
    end
  end

  assign pix_out.valid = p_valid;
  assign pix_out.red   = p_red;
  assign pix_out.green = p_green;

endmodule

/* sv/spectrum_bin_colorizer_core.sv */
// Spectrogram pixel generator: one complex FFT bin in, one RGB pixel out.
// Input channel: in_valid/in_ready carry bin_real and bin_imag (signed Q11.20,
// before the 1/FFT_LENGTH scaling). Output channel: out_valid/out_ready carry
// red, green and blue; blue is always full scale.
// A transaction is accepted on each channel whenever valid and ready are both
// high at a rising clock edge. One transaction may be accepted every cycle
// while the skid register is empty. The pipeline holds the 16 log2 squaring
// stages (one fraction bit each, one 31-bit multiplier per stage) and the
// six-stage divider by db_range.
// The db_range register sits at byte address 0 of the APB port and must be
// written only while the block is idle; the block itself does not enforce this. It resets to 85.
// Reset (synchronous, active high) clears every valid bit along the pipeline,
// including those of the output and skid registers, and reloads db_range.
// When the receiver stalls, the next finished pixel drops into the skid
// register and input is still taken; only once that register is also full do
// in_ready and the whole pipeline hold, and nothing is lost or repeated.
`include "spectrum_bin_colorizer_core_macros.svh"

module spectrum_bin_colorizer_core #(
  parameter int unsigned FFT_LENGTH = sbc_pkg::FFT_LENGTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         bin_real,
  input  logic signed [31:0]         bin_imag,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sbc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // The whole pipeline moves together while the skid register is empty.
  logic               adv;
  logic [7:0]         db_range;
  logic               skid_valid;
  logic [7:0]         skid_red;
  logic [7:0]         skid_green;
  sbc_pkg::pw_beat_t  pw_beat;
  sbc_pkg::l2_beat_t  l2_beat;
  sbc_pkg::quo_beat_t quo_beat;
  sbc_pkg::pix_beat_t pix;

  assign adv      = !skid_valid;
  assign in_ready = adv;
  assign blue     = sbc_pkg::FULL_LEVEL;

  // Configuration register. Writes to any other index are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[sbc_pkg::ADDR_W-1:2] == sbc_pkg::REG_DB_RANGE) ?
                  {24'd0, db_range} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      db_range <= sbc_pkg::DB_RANGE_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[sbc_pkg::ADDR_W-1:2] == sbc_pkg::REG_DB_RANGE) begin
      db_range <= pwdata[7:0];
    end
  end

  // Squares of the two components and the exact 64-bit power.
  sbc_power u_power (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .take     (in_valid),
    .bin_real (bin_real),
    .bin_imag (bin_imag),
    .pw_out   (pw_beat)
  );

  // Leading-one search, fraction by repeated squaring, offset removal.
  sbc_log2 #(
    .FFT_LENGTH (FFT_LENGTH)
  ) u_log2 (
    .clk    (clk),
    .rst    (rst),
    .adv    (adv),
    .pw_in  (pw_beat),
    .l2_out (l2_beat)
  );

  // Scaling to decibels and division by the configured span.
  sbc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .db_range (db_range),
    .l2_in    (l2_beat),
    .quo_out  (quo_beat)
  );

  // Clamp to the unit scale and map onto the colour ramp.
  sbc_color u_color (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .quo_in  (quo_beat),
    .pix_out (pix)
  );

  // Output register with a skid register behind it. A pixel leaving the
  // pipeline goes straight to the output when that is free or being taken,
  // and into the skid register otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (pix.valid) begin
      if (!out_valid || out_ready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        red   <= skid_red;
        green <= skid_green;
      end
    end else if (pix.valid) begin
      if (!out_valid || out_ready) begin
        red   <= pix.red;
        green <= pix.green;
      end else begin
        skid_red   <= pix.red;
        skid_green <= pix.green;
      end
    end
  end

  // A pixel only waits in the skid register behind one held at the output.
  `SBC_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  // The skid register only fills when the output was held by the receiver.
  `SBC_ASSERT_IMPL(a_skid_fill, $rose(skid_valid), $past(out_valid) && !$past(out_ready),
                   "skid filled without a stalled output")
  // A taken output empties the skid register in the following cycle.
  `SBC_ASSERT_NEXT(a_skid_drain, skid_valid && out_ready, !skid_valid, "skid did not drain")
  // While stalled the last pipeline stage keeps its pixel.
  `SBC_ASSERT_NEXT(a_stall_holds, skid_valid, $stable(pix), "pipeline moved while stalled")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Block-level bench for the spectrogram pixel generator.
//
// A sender process feeds complex FFT bins over the valid/ready input channel,
// and a receiver process drains RGB pixels over the output channel. Both sides
// insert random idle cycles, and some stretches run with no idling at all.
// Every accepted input transaction pushes the pixel it should produce onto a
// queue. Each accepted output transaction is compared with the oldest entry.
//
// The run is split into phases. Between phases the sender stops until every
// pending pixel has come back. The db_range register is then rewritten over
// the APB port and read back. The first phase starts with a short table of
// hand-picked bins: silence, the smallest non-zero bin, both full-scale
// corners and a few mid-range magnitudes. The random bins that follow spread
// their magnitudes over the whole logarithmic range.
module tb_top;

  localparam int unsigned FFT_LEN = sbc_pkg::FFT_LENGTH_DEFAULT;
  localparam int unsigned ADDR_W = sbc_pkg::ADDR_W;

  // Register i lives at byte address 4*i. The spare address is the first
  // index past the register list, so writes to it must be ignored.
  localparam logic [ADDR_W-1:0] ADDR_DB_RANGE = ADDR_W'(4 * sbc_pkg::REG_DB_RANGE);
  localparam logic [ADDR_W-1:0] ADDR_SPARE = ADDR_W'(4 * (sbc_pkg::REG_DB_RANGE + 1));

  // Fixed-point constants of the colour mapping, all in Q16.
  localparam longint UNITY = 65536;
  localparam longint DB_PER_OCTAVE = 98642;  // 5*log10(2)
  localparam longint SILENCE_LOG2 = -30 * UNITY;

  localparam int PIPE_LATENCY = 29;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int BINS_PER_PHASE = 205;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // One row of the directed table. Where known is set, the pixel is typed in
  // by hand. This is only done where it follows directly from the mapping at
  // the reset value of db_range.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               known;
    logic [7:0]         red;
    logic [7:0]         green;
  } bin_row_t;

  localparam int DIRECTED_ROWS = 14;
  localparam bin_row_t DIRECTED_BINS [0:DIRECTED_ROWS-1] = '{
    // Silence: magnitude is taken as 1/32768, giving s just under half scale.
    '{32'sd0, 32'sd0, 1'b1, 8'd15, 8'd255},
    // The smallest non-zero bin lies far below the range: s clamps to zero.
    '{32'sd1, 32'sd0, 1'b1, 8'd255, 8'd255},
    '{32'sd0, -32'sd1, 1'b1, 8'd255, 8'd255},
    // Both parts at their minimum: squared exactly, s clamps to one.
    '{32'sh8000_0000, 32'sh8000_0000, 1'b1, 8'd0, 8'd0},
    // A single part at its minimum gives exactly 0 dB, so s is exactly one.
    '{32'sd0, 32'sh8000_0000, 1'b1, 8'd0, 8'd0},
    '{32'sh7fff_ffff, 32'sd0, 1'b0, 8'd0, 8'd0},
    '{32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, 8'd0, 8'd0},
    '{32'sh0010_0000, 32'sd0, 1'b0, 8'd0, 8'd0},
    '{-32'sh0010_0000, 32'sh0010_0000, 1'b0, 8'd0, 8'd0},
    '{32'sh0000_0400, -32'sh0000_0300, 1'b0, 8'd0, 8'd0},
    '{32'sh5555_5555, 32'shaaaa_aaaa, 1'b0, 8'd0, 8'd0},
    '{32'sh0123_4567, -32'sh0765_4321, 1'b0, 8'd0, 8'd0},
    '{-32'sd1, -32'sd1, 1'b0, 8'd0, 8'd0},
    '{32'sh0000_ffff, 32'sh0001_0000, 1'b0, 8'd0, 8'd0}
  };

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] bin_real;
  logic signed [31:0] bin_imag;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // The bench's own copy of the register, updated at the write edge.
  logic [7:0] db_span;

  // Pixels owed by the block, oldest first.
  pixel_t pending_px [$];

  // Typed-in expectation for the bin currently on the input channel.
  logic       cur_known;
  logic [7:0] cur_red;
  logic [7:0] cur_green;

  int mismatch_count;
  int idle_cycles;
  int send_idle_max;
  int recv_idle_max;

  spectrum_bin_colorizer_core #(
    .FFT_LENGTH(FFT_LEN)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .bin_real (bin_real),
    .bin_imag (bin_imag),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Base-2 logarithm of a non-zero power in Q16. The integer part is the
  // position of the leading one. The fraction is built one bit per round by
  // squaring a Q1.30 mantissa and renormalising it whenever it reaches two.
  function automatic longint log2_fix16(input logic [63:0] x);
    int unsigned e;
    logic [63:0] m;
    logic [15:0] frac;
    e = 63;
    while (e > 0 && !x[e]) begin
      e--;
    end
    m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
    frac = '0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'(e) * UNITY + longint'(frac);
  endfunction

  // Predicted pixel for one bin at a given decibel span.
  function automatic pixel_t colour_of_bin(input logic signed [31:0] re,
                                           input logic signed [31:0] im,
                                           input logic [7:0] span);
    logic [31:0] mag_re;
    logic [31:0] mag_im;
    logic [63:0] power;
    longint      l2;
    longint      divisor;
    longint      s;
    longint      r;
    longint      g;
    pixel_t      px;
    // Absolute values; the minimum input maps to 2^31, which still fits.
    mag_re = re[31] ? (~re + 32'd1) : re;
    mag_im = im[31] ? (~im + 32'd1) : im;
    power = 64'(mag_re) * 64'(mag_re) + 64'(mag_im) * 64'(mag_im);
    divisor = longint'((span == 8'd0) ? 8'd1 : span) * UNITY;
    if (power == 64'd0) begin
      l2 = SILENCE_LOG2;
    end else begin
      // Undo the Q11.20 scaling (2^40 on the power) and the length scaling.
      l2 = log2_fix16(power) - 40 * UNITY - log2_fix16(64'(FFT_LEN) * 64'(FFT_LEN));
    end
    s = UNITY + (l2 * DB_PER_OCTAVE) / divisor;
    if (s < 0) begin
      s = 0;
    end
    if (s > UNITY) begin
      s = UNITY;
    end
    r = 510 * s;
    if (r > 255 * UNITY) begin
      r = 255 * UNITY;
    end
    g = s - UNITY / 2;
    if (g < 0) begin
      g = 0;
    end
    g = 510 * g;
    px.red = 8'(255 - (r + UNITY - 1) / UNITY);
    px.green = 8'(255 - (g + UNITY - 1) / UNITY);
    px.blue = 8'd255;
    return px;
  endfunction

  // Random bin component. Half of the draws shift a random word down by a random
  // amount so that magnitudes cover every octave, not just the top few.
  function automatic logic signed [31:0] draw_bin_part();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'd0;
      1: v = 32'h8000_0000;
      2: v = 32'h7fff_ffff;
      3, 4: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) begin
          v = ~v + 32'd1;
        end
      end
    endcase
    return v;
  endfunction

  // Offers one bin after an idle gap and returns at the edge that takes it.
  // The valid line is lowered once, at the start of the gap, and is never
  // dropped and raised again within one time step.
  task automatic send_bin(input logic signed [31:0] re, input logic signed [31:0] im,
                          input logic known, input logic [7:0] r, input logic [7:0] g);
    int gap;
    gap = $urandom_range(0, send_idle_max);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cur_known = known;
    cur_red = r;
    cur_green = g;
    in_valid <= 1'b1;
    bin_real <= re;
    bin_imag <= im;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering bins and waits until every owed pixel has arrived.
  task automatic drain_pixels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_px.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DB_RANGE) begin
      db_span = data[7:0];
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Reads db_range back and checks it against the bench's copy.
  task automatic apb_check_span();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_DB_RANGE;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== db_span) begin
      $error("db_range readback: expected %0d, actual %0d", db_span, prdata[7:0]);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Receiver: each pixel waits a random number of cycles before out_ready
  // rises. From time to time the whole side switches to a no-stall stretch.
  initial begin
    int stall;
    int taken;
    out_ready = 1'b0;
    taken = 0;
    recv_idle_max = 12;
    @(negedge clk);
    while (rst) begin
      @(negedge clk);
    end
    forever begin
      if (taken % 40 == 0) begin
        recv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
      end
      stall = $urandom_range(0, recv_idle_max);
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Scoreboard and watchdog. Inputs settle at the falling edge, so everything
  // read here at the rising edge is stable.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (cur_known) begin
          pending_px.insert(pending_px.size(),
                            '{red: cur_red, green: cur_green, blue: 8'd255});
        end else begin
          pending_px.insert(pending_px.size(), colour_of_bin(bin_real, bin_imag, db_span));
        end
      end
      if (out_valid && out_ready) begin
        if (pending_px.size() == 0) begin
          $error("pixel transaction with none outstanding: red %0d green %0d blue %0d",
                 red, green, blue);
          mismatch_count++;
        end else begin
          pixel_t want;
          want = pending_px.pop_front();
          if (red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, red);
            mismatch_count++;
          end
          if (green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, green);
            mismatch_count++;
          end
          if (blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, blue);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("spectrum_bin_colorizer_core test failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Main sequence: reset, directed table, then phases of random bins with a
  // register change (and a full drain) in between.
  initial begin
    logic [7:0] span_plan [0:PHASES-1];
    rst = 1'b1;
    in_valid = 1'b0;
    bin_real = '0;
    bin_imag = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_known = 1'b0;
    cur_red = '0;
    cur_green = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    send_idle_max = 12;
    db_span = sbc_pkg::DB_RANGE_RESET;

    // The first phase runs at the reset value. The rest cover both ends of
    // the register, the zero that is treated as one, and a few random spans.
    span_plan = '{sbc_pkg::DB_RANGE_RESET, 8'd1, 8'd255, 8'd0,
                  8'($urandom_range(1, 40)), 8'd128, 8'($urandom_range(1, 255)),
                  sbc_pkg::DB_RANGE_RESET};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_check_span();

    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      send_bin(DIRECTED_BINS[row].re, DIRECTED_BINS[row].im, DIRECTED_BINS[row].known,
               DIRECTED_BINS[row].red, DIRECTED_BINS[row].green);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain_pixels();
        // Upper data bits are random: only the low byte is the register.
        apb_write(ADDR_DB_RANGE, {8'($urandom), 16'($urandom), span_plan[phase]});
        apb_check_span();
        if (phase == 3) begin
          // A write past the register list must leave db_range untouched.
          apb_write(ADDR_SPARE, $urandom);
          apb_check_span();
        end
      end
      for (int n = 0; n < BINS_PER_PHASE; n++) begin
        if (n % 50 == 0) begin
          send_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
        end
        send_bin(draw_bin_part(), draw_bin_part(), 1'b0, 8'd0, 8'd0);
      end
    end

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_px.size() == 0) begin
      $display("spectrum_bin_colorizer_core test passed");
    end else begin
      $display("spectrum_bin_colorizer_core test failed");
    end
    $finish;
  end

endmodule
